[hw/rtl/swcl_pkg.sv]
// Shared codes and constants for the switch configuration lexer/checker.
// Token kinds, line status codes, scan modes, prefix codes and character codes.
// No dependencies.
package swcl_pkg;

  localparam int MAX_COLUMNS_DEF = 4096;
  localparam int VALUE_BITS_DEF  = 31;

  // open parenthesis nesting count, saturating
  localparam int          DEPTH_BITS = 12;
  localparam logic [11:0] DEPTH_MAX  = 12'd4095;

  typedef enum logic [2:0] {
    KIND_STATUS = 3'd0,
    KIND_NUM    = 3'd1,
    KIND_OPEN   = 3'd2,
    KIND_CLOSE  = 3'd3,
    KIND_SW     = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MISSING   = 2'd1,
    ST_UNKNOWN   = 2'd2,
    ST_UNMATCHED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MODE_SCAN    = 2'd0,
    MODE_COMMENT = 2'd1,
    MODE_ERROR   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    PRE_NONE  = 2'd0,
    PRE_S     = 2'd1,
    PRE_SLASH = 2'd2
  } prefix_t;

  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_W      = 8'h57;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_HASH   = 8'h23;

endpackage

[hw/rtl/switch_config_lexer_checker.sv]
// Switch configuration line lexer and checker, top level.
// Depends on swcl_pkg for kind, status, mode and character codes.
//
// Takes one character word per cycle and emits number, '(' , ')' and SW token
// words as they are recognized, then one status word (tlast high) per line.
// Each input word is handled in one pass: the lexer state registers and
// a short piece of classification/check logic feed a 4-entry result queue.
// A word yields zero, one or two results; the input is ready whenever the
// queue has two free entries, so with the output side taking a word every
// cycle the block sustains one character per cycle. A character that closes
// a number and is itself a token (or an end of line that closes a number)
// makes two results, and the output port drains one per cycle, so a long run
// of such characters makes the input wait on the queue. Tokens already sent
// are never withdrawn: a non-ok status tells the consumer to drop the line.
// Status priority: unknown character, then missing number at the start, at the
// end, then the first token-order fault (SW without '(' , unmatched ')',
// ')' without a number before it), then an unclosed '('. No clearing pass is
// needed after reset.
module switch_config_lexer_checker #(
  parameter int MAX_COLUMNS = swcl_pkg::MAX_COLUMNS_DEF,
  parameter int VALUE_BITS  = swcl_pkg::VALUE_BITS_DEF,
  localparam int COL_BITS   = $clog2(MAX_COLUMNS),
  localparam int DATA_W     = ((VALUE_BITS + COL_BITS + 2 + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  // input words: one character, or an end-of-line marker
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] ch
  input  logic              s_tlast,   // end_line
  // result words
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,   // value, column, status, zero pad
  output logic [2:0]        m_tuser,   // kind
  output logic              m_tlast    // last
);
  import swcl_pkg::*;

  localparam int Q_DEPTH = 4;
  localparam int Q_BITS  = $clog2(Q_DEPTH);

  // per-line checker state
  typedef struct packed {
    logic                token_seen;
    logic                first_ok;
    logic [COL_BITS-1:0] first_col;
    kind_t               prev_kind;
    logic [COL_BITS-1:0] prev_col;
    logic [DEPTH_BITS-1:0] open_depth;
    status_t             early_err;
    logic [COL_BITS-1:0] early_err_col;
  } chk_t;

  typedef struct packed {
    kind_t                 kind;
    logic [VALUE_BITS-1:0] value;
    logic [COL_BITS-1:0]   column;
    status_t               status;
    logic                  last;
  } res_t;

  localparam logic [COL_BITS-1:0] COL_MAX = COL_BITS'(MAX_COLUMNS - 1);

  function automatic chk_t tok_upd(chk_t s, kind_t k, logic [COL_BITS-1:0] c);
    chk_t r;
    r = s;
    if (!s.token_seen) begin
      r.token_seen = 1'b1;
      r.first_ok   = (k == KIND_NUM);
      r.first_col  = c;
    end else if (s.prev_kind == KIND_SW && k != KIND_OPEN && r.early_err == ST_OK) begin
      r.early_err     = ST_UNMATCHED;
      r.early_err_col = s.prev_col;
    end
    if (r.early_err == ST_OK) begin
      if (k == KIND_OPEN) begin
        if (r.open_depth < DEPTH_MAX) r.open_depth = r.open_depth + 1'b1;
      end else if (k == KIND_CLOSE) begin
        if (r.open_depth == '0) begin
          r.early_err     = ST_UNMATCHED;
          r.early_err_col = c;
        end else begin
          r.open_depth = r.open_depth - 1'b1;
          if (s.prev_kind != KIND_NUM) begin
            r.early_err     = ST_MISSING;
            r.early_err_col = c;
          end
        end
      end
    end
    r.prev_kind = k;
    r.prev_col  = c;
    return r;
  endfunction

  // lexer state
  mode_t                 mode, mode_next;
  prefix_t               pend, pend_next;
  logic [COL_BITS-1:0]   pend_col, pend_col_next;
  logic                  in_num, in_num_next;
  logic [VALUE_BITS-1:0] acc, acc_next;
  logic [COL_BITS-1:0]   num_col, num_col_next;
  logic [COL_BITS-1:0]   col_cnt, col_cnt_next;
  chk_t                  chk, chk_next;

  // result queue
  res_t              q_mem [Q_DEPTH];
  logic [Q_BITS-1:0] wr_ptr, rd_ptr;
  logic [Q_BITS:0]   q_cnt;

  logic in_fire, out_fire;
  assign s_tready = (q_cnt <= (Q_BITS+1)'(Q_DEPTH - 2));
  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;

  // single-pass step logic
  logic                  is_digit, is_delim, num_en, t2_en, stat_en, lex_en;
  kind_t                 t2_kind;
  logic [COL_BITS-1:0]   t2_col, lex_col;
  logic [VALUE_BITS+3:0] acc_prod;
  logic [VALUE_BITS-1:0] acc_base;
  chk_t                  chk_a, chk_b, chk_c;
  mode_t                 mode_e;
  status_t               stat_code;
  logic [COL_BITS-1:0]   stat_col;
  res_t                  res0, res1, r_num, r_t2, r_stat;
  logic [1:0]            n_res;

  assign is_digit = (s_tdata >= CH_0) && (s_tdata <= CH_9);
  assign is_delim = (s_tdata == CH_SPACE) || ((s_tdata >= CH_TAB) && (s_tdata <= CH_CR)) ||
                    (s_tdata == CH_COMMA) || (s_tdata == CH_SEMI);
  assign acc_base = in_num ? acc : '0;
  // acc*10 + digit; saturate once it passes the largest value
  assign acc_prod = {1'b0, acc_base, 3'b000} + {3'b000, acc_base, 1'b0} +
                    (VALUE_BITS+4)'(s_tdata[3:0]);

  always_comb begin
    mode_next     = mode;
    pend_next     = pend;
    pend_col_next = pend_col;
    in_num_next   = in_num;
    acc_next      = acc;
    num_col_next  = num_col;
    col_cnt_next  = col_cnt;
    num_en        = 1'b0;
    t2_en         = 1'b0;
    t2_kind       = KIND_SW;
    t2_col        = col_cnt;
    stat_en       = 1'b0;
    lex_en        = 1'b0;
    lex_col       = col_cnt;
    if (in_fire) begin
      if (s_tlast) begin
        stat_en = 1'b1;
        if (mode == MODE_SCAN) begin
          if (pend != PRE_NONE) begin
            lex_en  = 1'b1;
            lex_col = pend_col;
          end else begin
            num_en = in_num;
          end
        end
      end else begin
        if (col_cnt < COL_MAX) col_cnt_next = col_cnt + 1'b1;
        if (mode == MODE_SCAN) begin
          if (pend != PRE_NONE) begin
            pend_next = PRE_NONE;
            if (pend == PRE_S && s_tdata == CH_W) begin
              t2_en   = 1'b1;
              t2_kind = KIND_SW;
              t2_col  = pend_col;
            end else if (pend == PRE_SLASH && s_tdata == CH_SLASH) begin
              mode_next = MODE_COMMENT;
            end else begin
              lex_en  = 1'b1;
              lex_col = pend_col;
            end
          end else if (is_digit) begin
            if (!in_num) begin
              in_num_next  = 1'b1;
              num_col_next = col_cnt;
            end
            if (acc_prod[VALUE_BITS+3:VALUE_BITS] != '0) acc_next = '1;
            else acc_next = acc_prod[VALUE_BITS-1:0];
          end else begin
            num_en      = in_num;
            in_num_next = 1'b0;
            acc_next    = '0;
            if (is_delim) begin
              // skipped
            end else if (s_tdata == CH_LPAREN) begin
              t2_en   = 1'b1;
              t2_kind = KIND_OPEN;
            end else if (s_tdata == CH_RPAREN) begin
              t2_en   = 1'b1;
              t2_kind = KIND_CLOSE;
            end else if (s_tdata == CH_S) begin
              pend_next     = PRE_S;
              pend_col_next = col_cnt;
            end else if (s_tdata == CH_SLASH) begin
              pend_next     = PRE_SLASH;
              pend_col_next = col_cnt;
            end else if (s_tdata == CH_HASH) begin
              mode_next = MODE_COMMENT;
            end else begin
              lex_en = 1'b1;
            end
          end
        end
      end
      if (lex_en) begin
        mode_next   = MODE_ERROR;
        pend_next   = PRE_NONE;
        in_num_next = 1'b0;
        acc_next    = '0;
      end
      if (s_tlast) begin
        // every end of line returns the lexer to its reset state
        mode_next     = MODE_SCAN;
        pend_next     = PRE_NONE;
        pend_col_next = '0;
        in_num_next   = 1'b0;
        acc_next      = '0;
        num_col_next  = '0;
        col_cnt_next  = '0;
      end
    end
  end

  // token checks, in token order: pending number first, then the new token
  always_comb begin
    chk_a = num_en ? tok_upd(chk, KIND_NUM, num_col) : chk;
    chk_b = t2_en ? tok_upd(chk_a, t2_kind, t2_col) : chk_a;
    chk_c = chk_b;
    if (lex_en) chk_c.early_err_col = lex_col;
    chk_next = chk_c;
    if (in_fire && s_tlast) chk_next = '0;
  end

  assign mode_e = lex_en ? MODE_ERROR : mode;

  always_comb begin
    priority if (mode_e == MODE_ERROR) begin
      stat_code = ST_UNKNOWN;
      stat_col  = chk_c.early_err_col;
    end else if (!chk_c.token_seen) begin
      stat_code = ST_MISSING;
      stat_col  = '0;
    end else if (!chk_c.first_ok) begin
      stat_code = ST_MISSING;
      stat_col  = chk_c.first_col;
    end else if (chk_c.prev_kind != KIND_NUM) begin
      stat_code = ST_MISSING;
      stat_col  = chk_c.prev_col;
    end else if (chk_c.early_err != ST_OK) begin
      stat_code = chk_c.early_err;
      stat_col  = chk_c.early_err_col;
    end else if (chk_c.open_depth != '0) begin
      stat_code = ST_UNMATCHED;
      stat_col  = col_cnt;
    end else begin
      stat_code = ST_OK;
      stat_col  = '0;
    end
  end

  always_comb begin
    r_num  = '{kind: KIND_NUM, value: acc, column: num_col, status: ST_OK, last: 1'b0};
    r_t2   = '{kind: t2_kind, value: '0, column: t2_col, status: ST_OK, last: 1'b0};
    r_stat = '{kind: KIND_STATUS, value: '0, column: stat_col, status: stat_code,
               last: 1'b1};
    res0   = num_en ? r_num : (t2_en ? r_t2 : r_stat);
    res1   = t2_en ? r_t2 : r_stat;
    n_res  = 2'(num_en) + 2'(t2_en) + 2'(stat_en);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_SCAN;
      pend    <= PRE_NONE;
      pend_col <= '0;
      in_num  <= 1'b0;
      acc     <= '0;
      num_col <= '0;
      col_cnt <= '0;
      chk     <= '0;
    end else begin
      mode    <= mode_next;
      pend    <= pend_next;
      pend_col <= pend_col_next;
      in_num  <= in_num_next;
      acc     <= acc_next;
      num_col <= num_col_next;
      col_cnt <= col_cnt_next;
      chk     <= chk_next;
    end
  end

  // queue payload: up to two words written per accepted input
  always_ff @(posedge clk) begin
    if (in_fire && n_res != 2'd0) q_mem[wr_ptr] <= res0;
    if (in_fire && n_res == 2'd2) q_mem[wr_ptr + 1'b1] <= res1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      q_cnt  <= '0;
    end else begin
      if (in_fire) wr_ptr <= wr_ptr + Q_BITS'(n_res);
      if (out_fire) rd_ptr <= rd_ptr + 1'b1;
      q_cnt <= q_cnt + (Q_BITS+1)'(in_fire ? n_res : 2'd0) - (Q_BITS+1)'(out_fire);
    end
  end

  res_t head;
  assign head     = q_mem[rd_ptr];
  assign m_tvalid = (q_cnt != '0);
  assign m_tdata  = DATA_W'({head.status, head.column, head.value});
  assign m_tuser  = head.kind;
  assign m_tlast  = head.last;

  // checks
  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    q_cnt <= (Q_BITS+1)'(Q_DEPTH))
    else $error("result queue overfilled");

  a_eol_clears: assert property (@(posedge clk) disable iff (rst)
    in_fire && s_tlast |=> col_cnt == '0 && mode == MODE_SCAN && !in_num && chk == '0)
    else $error("line state not cleared after end of line");

  a_eol_status: assert property (@(posedge clk) disable iff (rst)
    in_fire && s_tlast |-> n_res != 2'd0 && ((n_res == 2'd1 && res0.last) ||
                                             (n_res == 2'd2 && res1.last)))
    else $error("end of line without a closing status word");

  a_num_scan: assert property (@(posedge clk) disable iff (rst)
    in_num |-> mode == MODE_SCAN && pend == PRE_NONE)
    else $error("number open outside normal scanning");

  a_pend_scan: assert property (@(posedge clk) disable iff (rst)
    pend != PRE_NONE |-> mode == MODE_SCAN)
    else $error("look-ahead prefix held outside normal scanning");

endmodule

[dv/tb_switch_config_lexer_checker.sv]
// Self-checking testbench for switch_config_lexer_checker: directed and random
// lines, a token scoreboard with its own lexer model, random source and sink stalls.
// Depends on swcl_pkg and the RTL top level.
module tb_switch_config_lexer_checker;
  import swcl_pkg::*;

  localparam int              IDLE_LIMIT   = 2000;
  localparam int              RANDOM_CHARS = 600;
  localparam logic [11:0]     COL_MAX      = 12'(MAX_COLUMNS_DEF - 1);
  localparam longint unsigned VALUE_MAX    = (64'd1 << VALUE_BITS_DEF) - 1;

  typedef struct {
    kind_t       kind;
    logic [30:0] value;
    logic [11:0] column;
    status_t     status;
    logic        last;
  } lex_word_t;

  // Lexer/checker model plus the queue of words it predicts.
  class token_scoreboard;
    lex_word_t       expected_words[$];
    int              errors;
    mode_t           mode;
    prefix_t         prefix;
    logic [11:0]     prefix_col;
    bit              in_num;
    longint unsigned num_acc;
    logic [11:0]     num_col;
    logic [11:0]     col_count;
    bit              token_seen;
    bit              first_is_num;
    logic [11:0]     first_col;
    kind_t           prev_kind;
    logic [11:0]     prev_col;
    logic [11:0]     depth;
    status_t         fault;
    logic [11:0]     fault_col;

    function new();
      errors = 0;
      clear_line();
    endfunction

    function void clear_line();
      mode         = MODE_SCAN;
      prefix       = PRE_NONE;
      prefix_col   = '0;
      in_num       = 1'b0;
      num_acc      = 0;
      num_col      = '0;
      col_count    = '0;
      token_seen   = 1'b0;
      first_is_num = 1'b0;
      first_col    = '0;
      prev_kind    = KIND_STATUS;
      prev_col     = '0;
      depth        = '0;
      fault        = ST_OK;
      fault_col    = '0;
    endfunction

    function void push(kind_t k, logic [30:0] v, logic [11:0] c, status_t s, logic l);
      lex_word_t w;
      w.kind   = k;
      w.value  = v;
      w.column = c;
      w.status = s;
      w.last   = l;
      expected_words.push_back(w);
    endfunction

    // only the first token-order fault of a line is kept
    function void set_fault(status_t code, logic [11:0] c);
      if (fault == ST_OK) begin
        fault     = code;
        fault_col = c;
      end
    endfunction

    function void emit_token(kind_t k, logic [30:0] v, logic [11:0] c);
      if (!token_seen) begin
        token_seen   = 1'b1;
        first_is_num = (k == KIND_NUM);
        first_col    = c;
      end else if (prev_kind == KIND_SW && k != KIND_OPEN) begin
        set_fault(ST_UNMATCHED, prev_col);
      end
      if (fault == ST_OK) begin
        if (k == KIND_OPEN) begin
          if (depth < DEPTH_MAX) depth++;
        end else if (k == KIND_CLOSE) begin
          if (depth == 0) begin
            set_fault(ST_UNMATCHED, c);
          end else begin
            depth--;
            if (prev_kind != KIND_NUM) set_fault(ST_MISSING, c);
          end
        end
      end
      prev_kind = k;
      prev_col  = c;
      push(k, v, c, ST_OK, 1'b0);
    endfunction

    function void close_number();
      if (in_num) begin
        emit_token(KIND_NUM, num_acc[30:0], num_col);
        in_num  = 1'b0;
        num_acc = 0;
      end
    endfunction

    // lexical error: the position overwrites the fault column, rest of line dropped
    function void enter_error(logic [11:0] c);
      mode      = MODE_ERROR;
      fault_col = c;
      prefix    = PRE_NONE;
      in_num    = 1'b0;
      num_acc   = 0;
    endfunction

    // one accepted input word
    function void note_char(logic [7:0] ch, logic eol);
      logic [11:0]     here;
      logic [11:0]     where;
      status_t         st;
      longint unsigned digit;
      if (eol) begin
        if (mode == MODE_SCAN) begin
          if (prefix != PRE_NONE) enter_error(prefix_col);
          else close_number();
        end
        if (mode == MODE_ERROR) begin
          st = ST_UNKNOWN; where = fault_col;
        end else if (!token_seen) begin
          st = ST_MISSING; where = '0;
        end else if (!first_is_num) begin
          st = ST_MISSING; where = first_col;
        end else if (prev_kind != KIND_NUM) begin
          st = ST_MISSING; where = prev_col;
        end else if (fault != ST_OK) begin
          st = fault; where = fault_col;
        end else if (depth != 0) begin
          st = ST_UNMATCHED; where = col_count;
        end else begin
          st = ST_OK; where = '0;
        end
        push(KIND_STATUS, '0, where, st, 1'b1);
        clear_line();
        return;
      end
      here = col_count;
      if (col_count != COL_MAX) col_count++;
      if (mode != MODE_SCAN) return;
      // held 'S' or '/' resolved by this character
      if (prefix != PRE_NONE) begin
        if (prefix == PRE_S && ch == CH_W) begin
          prefix = PRE_NONE;
          emit_token(KIND_SW, '0, prefix_col);
        end else if (prefix == PRE_SLASH && ch == CH_SLASH) begin
          prefix = PRE_NONE;
          mode   = MODE_COMMENT;
        end else begin
          enter_error(prefix_col);
        end
        return;
      end
      if (ch >= CH_0 && ch <= CH_9) begin
        digit = longint'(ch - CH_0);
        if (!in_num) begin
          in_num  = 1'b1;
          num_col = here;
          num_acc = 0;
        end
        if (num_acc > (VALUE_MAX - digit) / 10) num_acc = VALUE_MAX;
        else num_acc = num_acc * 10 + digit;
        return;
      end
      close_number();
      if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR) || ch == CH_COMMA ||
          ch == CH_SEMI) begin
        // delimiter
      end else if (ch == CH_LPAREN) begin
        emit_token(KIND_OPEN, '0, here);
      end else if (ch == CH_RPAREN) begin
        emit_token(KIND_CLOSE, '0, here);
      end else if (ch == CH_S) begin
        prefix     = PRE_S;
        prefix_col = here;
      end else if (ch == CH_SLASH) begin
        prefix     = PRE_SLASH;
        prefix_col = here;
      end else if (ch == CH_HASH) begin
        mode = MODE_COMMENT;
      end else begin
        enter_error(here);
      end
    endfunction

    // one accepted output word against the oldest prediction
    function void check_word(kind_t k, logic [30:0] v, logic [11:0] c, status_t s,
                             logic l);
      lex_word_t w;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word kind=%0d value=%0d column=%0d status=%0d last=%0b",
                 $time, k, v, c, s, l);
        errors++;
        return;
      end
      w = expected_words.pop_front();
      if (k !== w.kind) begin
        $display("%0t: kind expected %0d actual %0d", $time, w.kind, k);
        errors++;
      end
      if (v !== w.value) begin
        $display("%0t: value expected %0d actual %0d", $time, w.value, v);
        errors++;
      end
      if (c !== w.column) begin
        $display("%0t: column expected %0d actual %0d", $time, w.column, c);
        errors++;
      end
      if (s !== w.status) begin
        $display("%0t: status expected %0d actual %0d", $time, w.status, s);
        errors++;
      end
      if (l !== w.last) begin
        $display("%0t: last expected %0b actual %0b", $time, w.last, l);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;    // [7:0] ch
  logic        s_tlast;    // end_line
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;    // [30:0] value, [42:31] column, [44:43] status, zero pad
  logic [2:0]  m_tuser;    // [2:0] kind
  logic        m_tlast;    // last

  token_scoreboard sb;
  logic [7:0]      line_chars[$];
  int              burst_left;
  int              chars_sent;
  int              idle_cycles;
  logic [31:0]     ready_pattern;
  int              pattern_left;

  switch_config_lexer_checker DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // both handshakes sampled on the edge; each prediction is noted before its result
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_word(kind_t'(m_tuser), m_tdata[30:0], m_tdata[42:31],
                    status_t'(m_tdata[44:43]), m_tlast);
    if (!rst && s_tvalid && s_tready)
      sb.note_char(s_tdata, s_tlast);
  end

  // sink stalls: rotating random ready pattern, redrawn as pattern_left runs out
  initial pattern_left = 0;
  always @(posedge clk) begin
    if (pattern_left == 0) begin
      case ($urandom_range(0, 3))
        0:       ready_pattern = '1;
        1:       ready_pattern = $urandom() | 32'h1;
        2:       ready_pattern = ($urandom() & $urandom() & $urandom()) | 32'h1;
        default: ready_pattern = $urandom() | $urandom();
      endcase
      pattern_left = 48;
    end
    m_tready      <= ready_pattern[0];
    ready_pattern  = {ready_pattern[0], ready_pattern[31:1]};
    pattern_left--;
  end

  // watchdog on cycles with no word moving on either side
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Drive one word; source idles between bursts of random length.
  // Valid stays high across back-to-back words, so no low/high in one step.
  task automatic put_char(input logic [7:0] c, input logic eol);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 16);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= eol;
    do @(posedge clk); while (!s_tready);
    burst_left--;
  endtask

  task automatic send_line();
    foreach (line_chars[i]) put_char(line_chars[i], 1'b0);
    put_char(8'($urandom_range(0, 255)), 1'b1);  // ch is don't-care on end of line
    chars_sent += line_chars.size() + 1;
    line_chars.delete();
  endtask

  task automatic append_text(input string txt);
    for (int i = 0; i < txt.len(); i++) line_chars.push_back(txt[i]);
  endtask

  task automatic add_gap();
    repeat ($urandom_range(0, 2))
      case ($urandom_range(0, 3))
        0:       line_chars.push_back(CH_SPACE);
        1:       line_chars.push_back(CH_TAB + 8'($urandom_range(0, 4)));
        2:       line_chars.push_back(CH_COMMA);
        default: line_chars.push_back(CH_SEMI);
      endcase
  endtask

  // mostly short numbers, now and then long enough to saturate
  task automatic add_number();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 3);
    repeat (n) line_chars.push_back(CH_0 + 8'($urandom_range(0, 9)));
  endtask

  function automatic logic [7:0] odd_char();
    case ($urandom_range(0, 9))
      0:       return CH_S;
      1:       return CH_W;
      2:       return CH_SLASH;
      3:       return CH_HASH;
      4:       return CH_LPAREN;
      5:       return CH_RPAREN;
      6:       return CH_0;
      7:       return CH_SPACE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Well-formed "N (N) SW(N) N" shapes with random content; some get broken by
  // one or two edits, and a tenth are raw byte noise (empty lines included).
  task automatic build_random_line();
    int pick;
    int pos;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      repeat ($urandom_range(0, 8)) line_chars.push_back(8'($urandom_range(0, 255)));
      return;
    end
    add_gap();
    add_number();
    repeat ($urandom_range(0, 3)) begin
      add_gap();
      if ($urandom_range(0, 1)) begin
        append_text("SW");
        add_gap();
      end
      line_chars.push_back(CH_LPAREN);
      add_gap();
      add_number();
      if ($urandom_range(0, 3) == 0) begin
        line_chars.push_back(CH_LPAREN);
        add_number();
        line_chars.push_back(CH_RPAREN);
        add_gap();
        add_number();
      end
      add_gap();
      line_chars.push_back(CH_RPAREN);
      add_gap();
      add_number();
    end
    add_gap();
    case ($urandom_range(0, 5))
      0: begin
        line_chars.push_back(CH_HASH);
        repeat ($urandom_range(0, 4)) line_chars.push_back(8'($urandom_range(0, 255)));
      end
      1: begin
        append_text("//");
        repeat ($urandom_range(0, 4)) line_chars.push_back(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
    if (pick >= 70) begin
      repeat ($urandom_range(1, 2)) begin
        pos = $urandom_range(0, line_chars.size());
        case ($urandom_range(0, 2))
          0: if (pos < line_chars.size()) line_chars[pos] = odd_char();
          1: if (pos < line_chars.size()) line_chars.delete(pos);
          default: line_chars.insert(pos, odd_char());
        endcase
      end
    end
  endtask

  initial begin
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tlast    = 1'b0;
    m_tready   = 1'b0;
    burst_left = 0;
    chars_sent = 0;
    sb         = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty line: missing number at column 0
    send_line();
    // every token kind, a slash comment hiding a stray '('
    append_text("0SW(9)//(");
    send_line();
    // held 'S' cut off by end of line
    append_text("S");
    send_line();
    // byte above 127 is unknown
    line_chars.push_back(8'hFF);
    send_line();
    // number flushed by '/', then the bad look-ahead
    append_text("1/x");
    send_line();
    // '(' left open: reported at line length
    append_text("1(2");
    send_line();
    // ')' with no number before it
    append_text("()1");
    send_line();

    chars_sent = 0;
    while (chars_sent < RANDOM_CHARS) begin
      build_random_line();
      send_line();
    end
    s_tvalid <= 1'b0;

    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[switch_config_lexer_checker.f]
hw/rtl/swcl_pkg.sv
hw/rtl/switch_config_lexer_checker.sv
dv/tb_switch_config_lexer_checker.sv
